// ----- design/fcm_pkg.sv -----
package fcm_pkg;

    // Default table geometry.
    localparam int DEFAULT_MAX_COMMANDS = 16;
    localparam int DEFAULT_MAX_TEXT     = 20;

    // Width of the reported command index.
    localparam int INDEX_W = 4;

    // Number of entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Framing characters.
    localparam logic [7:0] FRAME_OPEN  = 8'h23;
    localparam logic [7:0] FRAME_CLOSE = 8'h25;

    // Request kinds on the input channel.
    localparam logic REQ_SERIAL = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // Operations handed from the front to the back.
    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD        = 2'd0;
    localparam op_t OP_STORE       = 2'd1;
    localparam op_t OP_STORE_MATCH = 2'd2;
    localparam op_t OP_MATCH       = 2'd3;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } fcm_op_t;

endpackage

// ----- design/fcm_ram.sv -----
module fcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 320
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/fcm_front.sv -----
module fcm_front #(
    parameter int MAX_TEXT = fcm_pkg::DEFAULT_MAX_TEXT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_req_type,
    input  logic [7:0]      s_data_byte,
    output logic            push_valid,
    output fcm_pkg::fcm_op_t push_op,
    input  logic            push_ready
);
    import fcm_pkg::*;

    localparam int POS_W = $clog2(MAX_TEXT);

    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W:0]   pos_inc;
    logic             accept;

    // A beat is taken whenever the queue has room, even if it turns out to be dropped.
    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;
    assign pos_inc = {1'b0, pos_reg} + 1'b1;

    // Classify each beat and track the frame position.
    always_comb begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        push_valid    = 1'b0;
        push_op.op    = OP_LOAD;
        push_op.data  = s_data_byte;
        if (accept) begin
            priority if (s_req_type == REQ_LOAD) begin
                push_valid = 1'b1;
                push_op.op = OP_LOAD;
            end else if (!in_frame_reg) begin
                if (s_data_byte == FRAME_OPEN) begin
                    in_frame_next = 1'b1;
                    pos_next      = '0;
                end
            end else if (s_data_byte == FRAME_CLOSE) begin
                push_valid    = 1'b1;
                push_op.op    = OP_MATCH;
                in_frame_next = 1'b0;
                pos_next      = '0;
            end else if (pos_inc == (POS_W + 1)'(MAX_TEXT)) begin
                push_valid    = 1'b1;
                push_op.op    = OP_STORE_MATCH;
                in_frame_next = 1'b0;
                pos_next      = '0;
            end else begin
                push_valid = 1'b1;
                push_op.op = OP_STORE;
                pos_next   = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

// ----- design/fcm_queue.sv -----
module fcm_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    input  fcm_pkg::fcm_op_t push_op,
    output logic             push_ready,
    output logic             pop_valid,
    output fcm_pkg::fcm_op_t pop_op,
    input  logic             pop_ready
);
    import fcm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    fcm_op_t          slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != (PTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_op     = slot[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Pointer and fill bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- design/fcm_back.sv -----
module fcm_back #(
    parameter int MAX_COMMANDS = fcm_pkg::DEFAULT_MAX_COMMANDS,
    parameter int MAX_TEXT     = fcm_pkg::DEFAULT_MAX_TEXT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pop_valid,
    input  fcm_pkg::fcm_op_t            pop_op,
    output logic                        pop_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_match_found,
    output logic [fcm_pkg::INDEX_W-1:0] m_command_index
);
    import fcm_pkg::*;

    localparam int POS_W  = $clog2(MAX_TEXT);
    localparam int LEN_W  = $clog2(MAX_TEXT + 1);
    localparam int CNT_W  = $clog2(MAX_COMMANDS + 1);
    localparam int IDX_W  = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
    localparam int DEPTH  = MAX_COMMANDS * MAX_TEXT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ENTRY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  load_pos_reg, load_pos_next;
    logic [ADDR_W-1:0] load_base_reg, load_base_next;
    logic [POS_W-1:0]  fpos_reg, fpos_next;
    logic [7:0]        fbuf_reg [MAX_TEXT];
    logic              fbuf_we;
    logic [CNT_W-1:0]  entry_reg, entry_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  len_mem [MAX_COMMANDS];
    logic              len_we;
    logic [LEN_W-1:0]  len_wdata;
    logic [LEN_W-1:0]  len_rd;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    logic [INDEX_W-1:0] m_index_reg, m_index_next;
    logic [POS_W:0]    load_inc, pos_inc;
    logic              needs_out;

    // Command text store.
    fcm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_text (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (pop_op.data),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign load_inc  = {1'b0, load_pos_reg} + 1'b1;
    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign len_rd    = len_mem[entry_reg[IDX_W-1:0]];
    assign needs_out = (pop_op.op == OP_MATCH) || (pop_op.op == OP_STORE_MATCH);
    assign pop_ready = (state_reg == ST_IDLE) && (!needs_out || !m_valid_reg);
    assign ram_waddr = load_base_reg + ADDR_W'(load_pos_reg);
    assign ram_raddr = (state_reg == ST_RUN) ? base_reg + ADDR_W'(pos_inc) : base_reg;

    assign m_valid         = m_valid_reg;
    assign m_match_found   = m_found_reg;
    assign m_command_index = m_index_reg;

    // Table loading, frame storing and the entry-by-entry match sequencer.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        load_pos_next  = load_pos_reg;
        load_base_next = load_base_reg;
        fpos_next      = fpos_reg;
        fbuf_we        = 1'b0;
        entry_next     = entry_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        len_we         = 1'b0;
        len_wdata      = LEN_W'(load_pos_reg);
        ram_we         = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_index_next   = m_index_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid && pop_ready) begin
                    unique case (pop_op.op)
                        OP_LOAD: begin
                            if (count_reg < CNT_W'(MAX_COMMANDS)) begin
                                if (pop_op.data == 8'd0) begin
                                    len_we         = 1'b1;
                                    count_next     = count_reg + 1'b1;
                                    load_pos_next  = '0;
                                    load_base_next = load_base_reg + ADDR_W'(MAX_TEXT);
                                end else begin
                                    ram_we = 1'b1;
                                    if (load_inc == (POS_W + 1)'(MAX_TEXT)) begin
                                        len_we         = 1'b1;
                                        len_wdata      = LEN_W'(MAX_TEXT);
                                        count_next     = count_reg + 1'b1;
                                        load_pos_next  = '0;
                                        load_base_next = load_base_reg + ADDR_W'(MAX_TEXT);
                                    end else begin
                                        load_pos_next = load_inc[POS_W-1:0];
                                    end
                                end
                            end
                        end
                        OP_STORE: begin
                            fbuf_we   = 1'b1;
                            fpos_next = fpos_reg + 1'b1;
                        end
                        OP_STORE_MATCH: begin
                            fbuf_we    = 1'b1;
                            fpos_next  = '0;
                            entry_next = '0;
                            base_next  = '0;
                            state_next = ST_ENTRY;
                        end
                        OP_MATCH: begin
                            fpos_next  = '0;
                            entry_next = '0;
                            base_next  = '0;
                            state_next = ST_ENTRY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ENTRY: begin
                // Start on the next closed entry, report a hit on an empty one, or report a miss past the last one.
                if (entry_reg == count_reg) begin
                    m_valid_next = 1'b1;
                    m_found_next = 1'b0;
                    m_index_next = '0;
                    state_next   = ST_IDLE;
                end else if (len_rd == '0) begin
                    m_valid_next = 1'b1;
                    m_found_next = 1'b1;
                    m_index_next = INDEX_W'(entry_reg);
                    state_next   = ST_IDLE;
                end else begin
                    len_next   = len_rd;
                    pos_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // One character compared per cycle while the next one is read.
                if (ram_rdata != fbuf_reg[pos_reg]) begin
                    entry_next = entry_reg + 1'b1;
                    base_next  = base_reg + ADDR_W'(MAX_TEXT);
                    state_next = ST_ENTRY;
                end else if (LEN_W'(pos_inc) == len_reg) begin
                    m_valid_next = 1'b1;
                    m_found_next = 1'b1;
                    m_index_next = INDEX_W'(entry_reg);
                    state_next   = ST_IDLE;
                end else begin
                    pos_next = pos_inc[POS_W-1:0];
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            load_pos_reg  <= '0;
            load_base_reg <= '0;
            fpos_reg      <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_TEXT; i++) begin
                fbuf_reg[i] <= 8'd0;
            end
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            load_pos_reg  <= load_pos_next;
            load_base_reg <= load_base_next;
            fpos_reg      <= fpos_next;
            m_valid_reg   <= m_valid_next;
            if (fbuf_we) begin
                fbuf_reg[fpos_reg] <= pop_op.data;
            end
        end
    end

    // Sequencer payload and result fields carry no reset.
    always_ff @(posedge aclk) begin
        entry_reg   <= entry_next;
        base_reg    <= base_next;
        pos_reg     <= pos_next;
        len_reg     <= len_next;
        m_found_reg <= m_found_next;
        m_index_reg <= m_index_next;
        if (len_we) begin
            len_mem[count_reg[IDX_W-1:0]] <= len_wdata;
        end
    end

endmodule

// ----- design/framed_command_matcher.sv -----
// Command table and framed-receive matcher. A beat with s_req_type high appends
// s_data_byte to the table entry being built (zero or a full entry closes it); a beat
// with s_req_type low is a received serial byte, framed by '#' and '%' or closed
// after MAX_TEXT stored bytes. Each closed frame yields one result beat naming the
// first table entry, in load order, whose text is a prefix of the frame buffer, or a miss.
// A front stage classifies beats into a small queue, so input beats are taken at one
// per cycle while the queue has room. Loads and frame bytes are handled in the back
// stage while it is idle; a frame close runs the entry-by-entry match sequencer,
// paced by the single read port of the command text memory, one character per cycle,
// and the back stage takes no new queue entry until the result is set.
module framed_command_matcher #(
    parameter int MAX_COMMANDS = fcm_pkg::DEFAULT_MAX_COMMANDS,
    parameter int MAX_TEXT     = fcm_pkg::DEFAULT_MAX_TEXT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [7:0]                  s_data_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_match_found,
    output logic [fcm_pkg::INDEX_W-1:0] m_command_index
);
    import fcm_pkg::*;

    logic    push_valid, push_ready;
    fcm_op_t push_op;
    logic    pop_valid, pop_ready;
    fcm_op_t pop_op;

    // Beat classification and frame tracking.
    fcm_front #(
        .MAX_TEXT (MAX_TEXT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_data_byte (s_data_byte),
        .push_valid  (push_valid),
        .push_op     (push_op),
        .push_ready  (push_ready)
    );

    // Decoupling queue.
    fcm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_op    (push_op),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_op     (pop_op),
        .pop_ready  (pop_ready)
    );

    // Table, frame buffer and matcher.
    fcm_back #(
        .MAX_COMMANDS (MAX_COMMANDS),
        .MAX_TEXT     (MAX_TEXT)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_op          (pop_op),
        .pop_ready       (pop_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match_found   (m_match_found),
        .m_command_index (m_command_index)
    );

endmodule
